// File: design/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define NCI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define NCI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/nci_pkg.sv
package nci_pkg;

  // fixed field widths
  localparam int POS_W       = 32;
  localparam int INV_W       = 32;
  localparam int CNT_REG_W   = 11;
  localparam int IDX_W       = 30;
  localparam int CODE_W      = 5;
  localparam int NUM_AXES    = 3;
  localparam int NUM_OFFS    = 3;

  // port widths
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = NUM_AXES * POS_W;
  localparam int OUT_TDATA_W = 32;

  // parameter defaults
  localparam int DEF_MAX_CELLS  = 1024;
  localparam int DEF_COORD_FRAC = 16;
  localparam int DEF_INV_FRAC   = 24;

  // reset value of the reciprocal registers, 1.0 with 24 fraction bits
  localparam logic [INV_W-1:0] INV_RESET = 32'h0100_0000;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // code of the final offset of a particle
  localparam logic [CODE_W-1:0] OFFSET_LAST = 5'd26;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELLS_X = 3'd0,
    CFG_CELLS_Y = 3'd1,
    CFG_CELLS_Z = 3'd2,
    CFG_INV_X   = 3'd3,
    CFG_INV_Y   = 3'd4,
    CFG_INV_Z   = 3'd5
  } cfg_reg_t;

endpackage

// File: design/nci_queue.sv
module nci_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [PTRW-1:0] PTR_LAST = PTRW'(DEPTH - 1);
  localparam logic [CNTW-1:0] CNT_FULL = CNTW'(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTRW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTRW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTRW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTRW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNTW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: design/nci_front.sv
module nci_front #(
  parameter int MAX_CELLS_PER_AXIS = 1024,
  parameter int COORD_FRAC_BITS    = 16,
  parameter int INV_FRAC_BITS      = 24,
  localparam int CNTW = $clog2(MAX_CELLS_PER_AXIS + 1),
  localparam int AXW  = (MAX_CELLS_PER_AXIS > 1) ? $clog2(MAX_CELLS_PER_AXIS) : 1,
  localparam int EW   = 9 * AXW
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  input  logic [nci_pkg::IN_TDATA_W-1:0]                in_tdata,
  input  logic [nci_pkg::NUM_AXES-1:0][nci_pkg::INV_W-1:0] inv_len,
  input  logic [nci_pkg::NUM_AXES-1:0][CNTW-1:0]        cells,
  input  logic                                          q_full,
  output logic                                          q_push,
  output logic [EW-1:0]                                 q_wdata
);

  import nci_pkg::*;

  localparam int SH = COORD_FRAC_BITS + INV_FRAC_BITS;
  localparam int PW = 2 * POS_W;
  localparam int HW = $clog2(MAX_CELLS_PER_AXIS + 2) + 1;
  localparam int VW = HW + 1;
  localparam logic [PW-1:0] LOW_MASK = (PW'(1) << SH) - PW'(1);

  logic adv;

  // stage valids
  logic a_v_r, b_v_r, c_v_r, d_v_r;

  // stage payloads
  logic [NUM_AXES-1:0][POS_W-1:0]         mag_r, mag_nxt;
  logic [NUM_AXES-1:0]                    neg_a_r, neg_a_nxt, neg_b_r;
  logic [NUM_AXES-1:0][PW-1:0]            prod_r;
  logic signed [HW-1:0]                   home_r   [NUM_AXES];
  logic signed [HW-1:0]                   home_nxt [NUM_AXES];
  logic [NUM_AXES-1:0][NUM_OFFS-1:0][AXW-1:0] wrap_r, wrap_nxt;

  // whole pipe moves unless the last stage is held by a full queue
  assign adv       = !d_v_r || !q_full;
  assign in_tready = adv;
  assign q_push    = d_v_r && !q_full;
  assign q_wdata   = wrap_r;

  // magnitude and sign of each coordinate
  always_comb begin
    logic [POS_W-1:0] pos;
    for (int a = 0; a < NUM_AXES; a++) begin
      pos          = in_tdata[a*POS_W +: POS_W];
      neg_a_nxt[a] = pos[POS_W-1];
      mag_nxt[a]   = pos[POS_W-1] ? (~pos + POS_W'(1)) : pos;
    end
  end

  // home cell from the scaled product, rounded toward minus infinity and clamped
  always_comb begin
    logic [PW-1:0] q;
    logic [PW-1:0] lim;
    logic          fnz;
    for (int a = 0; a < NUM_AXES; a++) begin
      q   = prod_r[a] >> SH;
      fnz = |(prod_r[a] & LOW_MASK);
      lim = PW'(cells[a]) + PW'(1);
      if (neg_b_r[a]) begin
        if ((q >= PW'(2)) || ((q == PW'(1)) && fnz)) begin
          home_nxt[a] = HW'(-2);
        end else if ((q == PW'(1)) || fnz) begin
          home_nxt[a] = HW'(-1);
        end else begin
          home_nxt[a] = '0;
        end
      end else if (q > lim) begin
        home_nxt[a] = $signed(HW'(lim));
      end else begin
        home_nxt[a] = $signed(HW'(q));
      end
    end
  end

  // periodic wrap of home-1, home, home+1 on each axis
  always_comb begin
    logic signed [VW-1:0] v;
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int o = 0; o < NUM_OFFS; o++) begin
        v = VW'(home_r[a]) + VW'(o) - VW'(1);
        if (v[VW-1]) begin
          wrap_nxt[a][o] = AXW'(cells[a] - CNTW'(1));
        end else if (v >= $signed(VW'(cells[a]))) begin
          wrap_nxt[a][o] = '0;
        end else begin
          wrap_nxt[a][o] = AXW'(v);
        end
      end
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_tvalid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      mag_r   <= mag_nxt;
      neg_a_r <= neg_a_nxt;
      neg_b_r <= neg_a_r;
      for (int a = 0; a < NUM_AXES; a++) begin
        prod_r[a] <= PW'(mag_r[a]) * PW'(inv_len[a]);
        home_r[a] <= home_nxt[a];
      end
      wrap_r <= wrap_nxt;
    end
  end

endmodule

// File: design/nci_back.sv
module nci_back #(
  parameter int MAX_CELLS_PER_AXIS = 1024,
  localparam int CNTW = $clog2(MAX_CELLS_PER_AXIS + 1),
  localparam int AXW  = (MAX_CELLS_PER_AXIS > 1) ? $clog2(MAX_CELLS_PER_AXIS) : 1,
  localparam int EW   = 9 * AXW
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  logic [EW-1:0]                     q_rdata,
  output logic                              q_pop,
  input  logic [CNTW-1:0]                   cells_z,
  input  logic [nci_pkg::IDX_W-1:0]         cells_yz,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [nci_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [nci_pkg::CODE_W-1:0]        out_tuser,
  output logic                              out_tlast
);

  import nci_pkg::*;

  localparam logic [1:0] OFF_MAX = 2'(NUM_OFFS - 1);

  logic [NUM_AXES-1:0][NUM_OFFS-1:0][AXW-1:0] ent;
  logic en, issue, last;
  logic [AXW-1:0] xs, ys, zs;

  // offset counters
  logic [1:0]        ox_r, ox_nxt, oy_r, oy_nxt, oz_r, oz_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;

  // product stage
  logic              p1_v_r;
  logic [IDX_W-1:0]  px_r, py_r;
  logic [AXW-1:0]    pz_r;
  logic [CODE_W-1:0] p1_code_r;
  logic              p1_last_r;

  // output register
  logic              out_v_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [CODE_W-1:0] out_code_r;
  logic              out_last_r;

  assign ent   = q_rdata;
  assign en    = !out_v_r || out_tready;
  assign issue = en && !q_empty;
  assign last  = (code_r == OFFSET_LAST);
  assign q_pop = issue && last;

  // pick the wrapped axis indexes of the current offset
  assign xs = ent[0][ox_r];
  assign ys = ent[1][oy_r];
  assign zs = ent[2][oz_r];

  // walk dz fastest, then dy, then dx
  always_comb begin
    ox_nxt   = ox_r;
    oy_nxt   = oy_r;
    oz_nxt   = oz_r;
    code_nxt = code_r;
    if (issue) begin
      if (last) begin
        ox_nxt   = '0;
        oy_nxt   = '0;
        oz_nxt   = '0;
        code_nxt = '0;
      end else begin
        code_nxt = code_r + CODE_W'(1);
        if (oz_r != OFF_MAX) begin
          oz_nxt = oz_r + 2'd1;
        end else begin
          oz_nxt = '0;
          if (oy_r != OFF_MAX) begin
            oy_nxt = oy_r + 2'd1;
          end else begin
            oy_nxt = '0;
            ox_nxt = ox_r + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r    <= '0;
      oy_r    <= '0;
      oz_r    <= '0;
      code_r  <= '0;
      p1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      ox_r   <= ox_nxt;
      oy_r   <= oy_nxt;
      oz_r   <= oz_nxt;
      code_r <= code_nxt;
      if (en) begin
        p1_v_r  <= issue;
        out_v_r <= p1_v_r;
      end
    end
  end

  // row products, then the final sum
  always_ff @(posedge clk) begin
    if (en) begin
      px_r       <= IDX_W'(IDX_W'(xs) * cells_yz);
      py_r       <= IDX_W'(IDX_W'(ys) * IDX_W'(cells_z));
      pz_r       <= zs;
      p1_code_r  <= code_r;
      p1_last_r  <= last;
      out_idx_r  <= px_r + py_r + IDX_W'(pz_r);
      out_code_r <= p1_code_r;
      out_last_r <= p1_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_TDATA_W - IDX_W){1'b0}}, out_idx_r};
  assign out_tuser  = out_code_r;
  assign out_tlast  = out_last_r;

endmodule

// File: design/neighbor_cell_index_generator_core.sv
// positions pass front stages a-d, the queue, the product stage and the output register
// throughput: 27 index beats per particle, one per cycle unless out_tready is low
//   or the queue is empty, set by the back end emitting one neighbor index per clock
// the front pipeline and a 2-entry queue take new positions while the back end is busy
// reset: synchronous active-low rst_n clears all control state and sets the counts to 1
//   and the reciprocals to 1.0; no clearing pass
`include "assert_macros.svh"

module neighbor_cell_index_generator_core #(
  parameter int MAX_CELLS_PER_AXIS = nci_pkg::DEF_MAX_CELLS,
  parameter int COORD_FRAC_BITS    = nci_pkg::DEF_COORD_FRAC,
  parameter int INV_FRAC_BITS      = nci_pkg::DEF_INV_FRAC
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // pos_x [31:0], pos_y [63:32], pos_z [95:64]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [nci_pkg::IN_TDATA_W-1:0]    in_tdata,
  // cell_index [29:0], zero fill [31:30]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [nci_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // offset_code [4:0]
  output logic [nci_pkg::CODE_W-1:0]        out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nci_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nci_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import nci_pkg::*;

  localparam int CNTW = $clog2(MAX_CELLS_PER_AXIS + 1);
  localparam int AXW  = (MAX_CELLS_PER_AXIS > 1) ? $clog2(MAX_CELLS_PER_AXIS) : 1;
  localparam int EW   = 9 * AXW;
  localparam int CMPW = ((CNTW > CNT_REG_W) ? CNTW : CNT_REG_W) + 1;

  // configuration registers, counts held as effective values
  logic [NUM_AXES-1:0][CNTW-1:0]  cells_r;
  logic [NUM_AXES-1:0][INV_W-1:0] inv_r;
  logic [IDX_W-1:0]               cells_yz_r;
  logic [2*CNTW-1:0]              yz_full;
  logic [CNT_REG_W-1:0]           cnt_raw;
  logic [CNTW-1:0]                cnt_eff;

  // queue between front and back
  logic          q_push, q_full, q_pop, q_empty;
  logic [EW-1:0] q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  // zero count acts as one, oversized count saturates
  assign cnt_raw = cfg_data[CNT_REG_W-1:0];
  always_comb begin
    if (cnt_raw == '0) begin
      cnt_eff = CNTW'(1);
    end else if (CMPW'(cnt_raw) > CMPW'(MAX_CELLS_PER_AXIS)) begin
      cnt_eff = CNTW'(MAX_CELLS_PER_AXIS);
    end else begin
      cnt_eff = CNTW'(cnt_raw);
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        cells_r[a] <= CNTW'(1);
        inv_r[a]   <= INV_RESET;
      end
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CELLS_X: cells_r[0] <= cnt_eff;
        CFG_CELLS_Y: cells_r[1] <= cnt_eff;
        CFG_CELLS_Z: cells_r[2] <= cnt_eff;
        CFG_INV_X:   inv_r[0]   <= cfg_data[INV_W-1:0];
        CFG_INV_Y:   inv_r[1]   <= cfg_data[INV_W-1:0];
        CFG_INV_Z:   inv_r[2]   <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // plane size in cells, ny*nz
  assign yz_full = cells_r[1] * cells_r[2];
  always_ff @(posedge clk) begin
    cells_yz_r <= IDX_W'(yz_full);
  end

  nci_front #(
    .MAX_CELLS_PER_AXIS (MAX_CELLS_PER_AXIS),
    .COORD_FRAC_BITS    (COORD_FRAC_BITS),
    .INV_FRAC_BITS      (INV_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .inv_len   (inv_r),
    .cells     (cells_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  nci_queue #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  nci_back #(
    .MAX_CELLS_PER_AXIS (MAX_CELLS_PER_AXIS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .cells_z    (cells_r[2]),
    .cells_yz   (cells_yz_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // checks
  `NCI_ASSERT_IMPL(a_no_queue_overflow, q_push, !q_full, "push into a full queue")
  `NCI_ASSERT_IMPL(a_last_code, out_tvalid, out_tlast == (out_tuser == OFFSET_LAST), "bad tlast")
  `NCI_ASSERT_NEXT(a_gapless, out_tvalid && out_tready && !out_tlast, out_tvalid, "gap in run")

endmodule
